// File: rtl/core/bpa_pkg.sv
// Shared types, constants and helpers for the bank page allocator.
// No dependencies; every file of the block imports this package.
package bpa_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned MapSlots   = 4;
  localparam int unsigned BankShift  = 14;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CntW       = 7;

  localparam logic [7:0] NoPage = 8'hff;

  typedef logic [AddrW-1:0] stack_addr_t;
  typedef logic [CntW-1:0]  stack_cnt_t;
  typedef logic [7:0]       page_t;

  localparam logic [1:0] CmdAdd    = 2'd0;
  localparam logic [1:0] CmdAlloc  = 2'd1;
  localparam logic [1:0] CmdFree   = 2'd2;
  localparam logic [1:0] CmdResize = 2'd3;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusOom      = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  page_number;
    logic [15:0] size_top;
    logic [15:0] old_top;
    logic [7:0]  map_in_0;
    logic [7:0]  map_in_1;
    logic [7:0]  map_in_2;
    logic [7:0]  map_in_3;
  } bpa_in_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  map_out_0;
    logic [7:0]  map_out_1;
    logic [7:0]  map_out_2;
    logic [7:0]  map_out_3;
    logic [6:0]  free_pages;
    logic [11:0] used_kb;
  } bpa_out_t;

  // Number of 16K banks covering a top address: 1 to 4.
  function automatic logic [2:0] pages_for(input logic [15:0] top);
    logic [15:0] t;
    t = (top != 16'd0) ? top - 16'd1 : 16'd0;
    return 3'(t >> BankShift) + 3'd1;
  endfunction

  // Slot mask for the half-open slot range [lo, hi).
  function automatic logic [MapSlots-1:0] slot_range(input logic [2:0] lo,
                                                     input logic [2:0] hi);
    logic [MapSlots-1:0] m;
    for (int i = 0; i < MapSlots; i++) begin
      m[i] = (3'(i) >= lo) && (3'(i) < hi);
    end
    return m;
  endfunction

endpackage

// File: rtl/core/bpa_stack_ram.sv
// Free-page stack storage: one write port, one read port, registered read.
// Depends on bpa_pkg for the depth and address type.
module bpa_stack_ram (
  input  logic                clk_i,
  input  logic                we_i,
  input  bpa_pkg::stack_addr_t waddr_i,
  input  bpa_pkg::page_t      wdata_i,
  input  logic                re_i,
  input  bpa_pkg::stack_addr_t raddr_i,
  output bpa_pkg::page_t      rdata_o
);
  import bpa_pkg::*;

  page_t mem_q [StackDepth];
  page_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bank_page_allocator.sv
// Bank page allocator top level: command decode, slot sequencer, result register.
// Depends on bpa_pkg and bpa_stack_ram.
//
// Keeps a stack of free 16K bank numbers in a 64-entry single-port-pair RAM and
// serves add, allocate, free and resize commands against a four-slot map. Decode
// happens in the transfer cycle, then the sequencer steps through the map slots in
// order (each slot does at most one stack push or pop through the RAM port, a pop's
// data landing in the next cycle), and the fill state applies the repeat-fill and
// loads the result register once the output register is free. A new command is
// taken once the previous one has reached the result register, even while that
// result still waits for its transfer. No clearing pass follows reset: the stack
// is empty. process_memory_kb is to be written by the user through cfg_we_i /
// cfg_wdata_i only while idle; the block itself does not enforce this.
module bank_page_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [11:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bpa_pkg::bpa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpa_pkg::bpa_out_t out_data_o
);
  import bpa_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFill = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [1:0]          idx_q;
  logic [MapSlots-1:0] push_mask_q, pop_mask_q;
  page_t               push_val_q [MapSlots];
  page_t               map_q [MapSlots];
  logic [2:0]          fill_q;
  status_e             status_q;
  stack_cnt_t          cnt_q;
  logic                cap_valid_q;
  logic [1:0]          cap_slot_q;
  logic [11:0]         pmk_q;
  logic                out_valid_q;
  bpa_out_t            out_data_q;

  // decode
  page_t               map_in [MapSlots];
  page_t               map_init [MapSlots];
  page_t               push_init [MapSlots];
  logic [MapSlots-1:0] diff, push_mask_d, pop_mask_d;
  logic [2:0]          npush, need, have, want, fill_d;
  status_e             status_d;
  logic [CntW:0]       cnt_ext;
  logic                in_xfer;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cnt_ext    = {1'b0, cnt_q};

  always_comb begin
    map_in[0] = in_data_i.map_in_0;
    map_in[1] = in_data_i.map_in_1;
    map_in[2] = in_data_i.map_in_2;
    map_in[3] = in_data_i.map_in_3;
    diff[0] = (map_in[0] != NoPage);
    for (int i = 1; i < MapSlots; i++) begin
      diff[i] = (map_in[i] != map_in[i-1]);
    end
    npush = 3'(diff[0]) + 3'(diff[1]) + 3'(diff[2]) + 3'(diff[3]);
    need  = pages_for(in_data_i.size_top);
    want  = need;
    have  = pages_for(in_data_i.old_top);

    map_init    = map_in;
    push_init   = map_in;
    push_mask_d = '0;
    pop_mask_d  = '0;
    fill_d      = 3'd4;
    status_d    = StatusOk;
    unique case (in_data_i.command)
      CmdAdd: begin
        map_init     = '{default: '0};
        push_init[0] = in_data_i.page_number;
        if (cnt_ext >= (CntW+1)'(StackDepth)) begin
          status_d = StatusOverflow;
        end else begin
          push_mask_d = 4'b0001;
        end
      end
      CmdAlloc: begin
        map_init = '{default: '0};
        if ((CntW+1)'(need) > cnt_ext) begin
          status_d = StatusOom;
        end else begin
          pop_mask_d = slot_range(3'd0, need);
          fill_d     = need;
        end
      end
      CmdFree: begin
        if (cnt_ext + (CntW+1)'(npush) > (CntW+1)'(StackDepth)) begin
          status_d = StatusOverflow;
        end else begin
          push_mask_d = diff;
        end
      end
      CmdResize: begin
        if (have > want) begin
          if (cnt_ext + (CntW+1)'(have - want) > (CntW+1)'(StackDepth)) begin
            status_d = StatusOverflow;
          end else begin
            push_mask_d = slot_range(want, have);
            fill_d      = want;
          end
        end else if (want > have) begin
          if ((CntW+1)'(want - have) > cnt_ext) begin
            status_d = StatusOom;
          end else begin
            pop_mask_d = slot_range(have, want);
            fill_d     = want;
          end
        end
      end
      default: ;
    endcase
  end

  // stack port
  logic        mem_we, mem_re;
  page_t       mem_wdata, mem_rdata;
  stack_addr_t mem_waddr, mem_raddr;
  stack_cnt_t  cnt_m1;

  assign cnt_m1    = cnt_q - stack_cnt_t'(1);
  assign mem_we    = (state_q == StRun) && push_mask_q[idx_q];
  assign mem_re    = (state_q == StRun) && pop_mask_q[idx_q];
  assign mem_wdata = push_val_q[idx_q];
  assign mem_waddr = cnt_q[AddrW-1:0];
  assign mem_raddr = cnt_m1[AddrW-1:0];

  bpa_stack_ram u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // popped data lands in the cycle after the read
  page_t      map_cap [MapSlots];
  page_t      map_fin [MapSlots];
  logic [2:0] fill_m1;
  always_comb begin
    map_cap = map_q;
    if (cap_valid_q) begin
      map_cap[cap_slot_q] = mem_rdata;
    end
    fill_m1 = fill_q - 3'd1;
    for (int i = 0; i < MapSlots; i++) begin
      map_fin[i] = (3'(i) >= fill_q) ? map_cap[fill_m1[1:0]] : map_cap[i];
    end
  end

  logic        out_load;
  logic [10:0] in_free_kb;
  logic [11:0] used_kb;
  assign in_free_kb = {cnt_q, 4'b0000};
  assign used_kb    = (pmk_q > 12'(in_free_kb)) ? pmk_q - 12'(in_free_kb) : 12'd0;
  assign out_load   = (state_q == StFill) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_xfer) state_d = StRun;
      StRun:   if (idx_q == 2'd3) state_d = StFill;
      StFill:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= 2'd0;
      cnt_q       <= '0;
      cap_valid_q <= 1'b0;
      pmk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_valid_q <= mem_re;
      if (cfg_we_i) pmk_q <= cfg_wdata_i;
      if (in_xfer) begin
        idx_q <= 2'd0;
      end else if (state_q == StRun) begin
        idx_q <= idx_q + 2'd1;
      end
      if (mem_we) begin
        cnt_q <= cnt_q + stack_cnt_t'(1);
      end else if (mem_re) begin
        cnt_q <= cnt_m1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      push_mask_q <= push_mask_d;
      pop_mask_q  <= pop_mask_d;
      fill_q      <= fill_d;
      status_q    <= status_d;
      map_q       <= map_init;
      push_val_q  <= push_init;
    end else begin
      map_q <= map_cap;
    end
    if (mem_re) cap_slot_q <= idx_q;
    if (out_load) begin
      out_data_q.status     <= status_q;
      out_data_q.map_out_0  <= map_fin[0];
      out_data_q.map_out_1  <= map_fin[1];
      out_data_q.map_out_2  <= map_fin[2];
      out_data_q.map_out_3  <= map_fin[3];
      out_data_q.free_pages <= cnt_q;
      out_data_q.used_kb    <= used_kb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stack_cnt_t'(StackDepth))
    else $error("free stack count above depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (cnt_q < stack_cnt_t'(StackDepth)))
    else $error("push onto full stack");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (cnt_q != '0))
    else $error("pop from empty stack");
  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("push and pop in one cycle");
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == StRun) && (idx_q == 2'd0))
    else $error("accepted command did not start slot sequence");
`endif

endmodule
